// File: sv/slfha_pkg.sv
// ----------------------------------------------------------------------------
// slfha_pkg
// Shared sizes, codes and types of the scoped lowest-free handle allocator.
// ----------------------------------------------------------------------------
package slfha_pkg;

    localparam int SLOTS   = 64;
    localparam int FRAMES  = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    localparam int ACTION_W = 3;
    localparam int HANDLE_W = 6;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQUIRE = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_PUSH    = 3'd2,
        ACT_POP     = 3'd3,
        ACT_CLEAR   = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_FULL     = 2'd2,
        ST_BASE_POP = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_PUSH,
        OP_POP
    } t_stack_op;

    typedef struct packed {
        t_stack_op              op;
        logic [SLOTS-1:0]       bits;
    } t_stack_cmd;

endpackage

// File: sv/scoped_lowest_free_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// scoped_lowest_free_handle_allocator_core
// Stack of slot bitmaps; acquire grants the lowest free slot of the top frame.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   command  | start / busy        | i_action, i_handle_id
//   result   | o_valid (strobe)    | o_granted_handle, o_status, o_frame_level
//
// One item per cycle; its result strobes in the cycle after it is taken.
// The rate is set by the find-first-free encoder on the top bitmap and the
// frame memory's single registered read.
// busy is always low. Reset leaves one empty base frame; it needs no sweep.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module scoped_lowest_free_handle_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [slfha_pkg::ACTION_W-1:0] i_action,
    input  logic [slfha_pkg::HANDLE_W-1:0] i_handle_id,
    output logic                           o_valid,
    output logic [slfha_pkg::HANDLE_W-1:0] o_granted_handle,
    output logic [slfha_pkg::STATUS_W-1:0] o_status,
    output logic [slfha_pkg::LEVEL_W-1:0]  o_frame_level
);

    logic                            w_accept;
    logic [slfha_pkg::SLOTS-1:0]     w_top;
    logic [slfha_pkg::FRAME_W-1:0]   w_level;
    logic                            w_full;
    logic [slfha_pkg::SLOT_W-1:0]    w_free;
    logic [slfha_pkg::SLOT_W-1:0]    w_rel_idx;
    slfha_pkg::t_stack_cmd           w_cmd;
    slfha_pkg::t_status              w_status;
    logic [slfha_pkg::SLOT_W-1:0]    w_grant;
    logic [slfha_pkg::FRAME_W-1:0]   w_level_after;

    logic                            r_valid;
    logic [slfha_pkg::HANDLE_W-1:0]  r_granted;
    slfha_pkg::t_status              r_status;
    logic [slfha_pkg::LEVEL_W-1:0]   r_level_out;

    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_rel_idx = slfha_pkg::SLOT_W'(i_handle_id);

    slfha_ffs u_ffs (
        .i_bits  (w_top),
        .o_full  (w_full),
        .o_index (w_free)
    );

    always_comb begin
        w_cmd.op      = slfha_pkg::OP_HOLD;
        w_cmd.bits    = w_top;
        w_status      = slfha_pkg::ST_OK;
        w_grant       = '0;
        w_level_after = w_level;
        if (w_accept) begin
            unique case (slfha_pkg::t_action'(i_action))
                slfha_pkg::ACT_ACQUIRE: begin
                    if (w_full) begin
                        w_status = slfha_pkg::ST_NO_FREE;
                    end else begin
                        w_cmd.op           = slfha_pkg::OP_WRITE;
                        w_cmd.bits[w_free] = 1'b1;
                        w_grant            = w_free;
                    end
                end
                slfha_pkg::ACT_RELEASE: begin
                    if (32'(i_handle_id) < 32'(slfha_pkg::SLOTS)) begin
                        w_cmd.op              = slfha_pkg::OP_WRITE;
                        w_cmd.bits[w_rel_idx] = 1'b0;
                    end
                end
                slfha_pkg::ACT_PUSH: begin
                    if (w_level == slfha_pkg::FRAME_W'(slfha_pkg::FRAMES - 1)) begin
                        w_status = slfha_pkg::ST_FULL;
                    end else begin
                        w_cmd.op      = slfha_pkg::OP_PUSH;
                        w_level_after = w_level + slfha_pkg::FRAME_W'(1);
                    end
                end
                slfha_pkg::ACT_POP: begin
                    if (w_level == '0) begin
                        w_status = slfha_pkg::ST_BASE_POP;
                    end else begin
                        w_cmd.op      = slfha_pkg::OP_POP;
                        w_level_after = w_level - slfha_pkg::FRAME_W'(1);
                    end
                end
                slfha_pkg::ACT_CLEAR: begin
                    w_cmd.op   = slfha_pkg::OP_WRITE;
                    w_cmd.bits = '0;
                end
                default: ;
            endcase
        end
    end

    slfha_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_top   (w_top),
        .o_level (w_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
        r_granted   <= slfha_pkg::HANDLE_W'(w_grant);
        r_status    <= w_status;
        r_level_out <= slfha_pkg::LEVEL_W'(w_level_after);
    end

    assign o_valid          = r_valid;
    assign o_granted_handle = r_granted;
    assign o_status         = r_status;
    assign o_frame_level    = r_level_out;

endmodule

// File: sv/slfha_ffs.sv
// ----------------------------------------------------------------------------
// slfha_ffs
// Finds the lowest clear bit of the top frame's slot bitmap.
// ----------------------------------------------------------------------------
module slfha_ffs (
    input  logic [slfha_pkg::SLOTS-1:0]  i_bits,
    output logic                         o_full,
    output logic [slfha_pkg::SLOT_W-1:0] o_index
);

    logic [slfha_pkg::SLOTS-1:0] w_low;

    // isolate lowest zero: one-hot, or zero when every slot is taken
    assign w_low  = ~i_bits & (i_bits + slfha_pkg::SLOTS'(1));
    assign o_full = &i_bits;

    always_comb begin
        o_index = '0;
        for (int i = 0; i < slfha_pkg::SLOTS; i++) begin
            if (w_low[i]) begin
                o_index = o_index | slfha_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// File: sv/slfha_stack.sv
// ----------------------------------------------------------------------------
// slfha_stack
// Frame stack: top and next-lower bitmaps in registers, deeper frames in a
// memory whose registered read always holds the frame two below the top.
// ----------------------------------------------------------------------------
module slfha_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slfha_pkg::t_stack_cmd         i_cmd,
    output logic [slfha_pkg::SLOTS-1:0]   o_top,
    output logic [slfha_pkg::FRAME_W-1:0] o_level
);

    logic [slfha_pkg::SLOTS-1:0]   r_mem [slfha_pkg::FRAMES];
    logic [slfha_pkg::SLOTS-1:0]   r_top;
    logic [slfha_pkg::SLOTS-1:0]   r_below;
    logic [slfha_pkg::SLOTS-1:0]   r_rd;
    logic [slfha_pkg::FRAME_W-1:0] r_level;
    logic [slfha_pkg::FRAME_W-1:0] n_level;
    logic [slfha_pkg::FRAME_W-1:0] w_rd_addr;
    logic [slfha_pkg::FRAME_W-1:0] w_wr_addr;

    always_comb begin
        case (i_cmd.op)
            slfha_pkg::OP_PUSH: n_level = r_level + slfha_pkg::FRAME_W'(1);
            slfha_pkg::OP_POP:  n_level = r_level - slfha_pkg::FRAME_W'(1);
            default:            n_level = r_level;
        endcase
    end

    assign w_rd_addr = n_level - slfha_pkg::FRAME_W'(2);
    assign w_wr_addr = r_level - slfha_pkg::FRAME_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_top   <= '0;
            r_below <= '0;
        end else begin
            r_level <= n_level;
            case (i_cmd.op)
                slfha_pkg::OP_WRITE: r_top <= i_cmd.bits;
                slfha_pkg::OP_PUSH: begin
                    r_below <= r_top;
                    r_top   <= '0;
                end
                slfha_pkg::OP_POP: begin
                    r_top   <= r_below;
                    r_below <= r_rd;
                end
                default: ;
            endcase
        end
    end

    // push writes the old lower frame; read-after-write goes around the memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == slfha_pkg::OP_PUSH && r_level != '0) begin
            r_mem[w_wr_addr] <= r_below;
        end
        if (i_cmd.op == slfha_pkg::OP_PUSH) begin
            r_rd <= r_below;
        end else begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assign o_top   = r_top;
    assign o_level = r_level;

endmodule

// File: sv/slfha_checker.sv
// ----------------------------------------------------------------------------
// slfha_checker
// Port-level checks of the allocator core, bound into the core module.
// ----------------------------------------------------------------------------
module slfha_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_valid,
    input logic [slfha_pkg::HANDLE_W-1:0] o_granted_handle,
    input logic [slfha_pkg::STATUS_W-1:0] o_status,
    input logic [slfha_pkg::LEVEL_W-1:0]  o_frame_level
);

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted item gave no result strobe");

    a_no_extra: assert property (@(posedge i_clk)
        (!i_rst_n || !(start && !busy)) |=> !o_valid)
        else $error("result strobe without an accepted item");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted_handle != '0) |-> (o_status == slfha_pkg::ST_OK))
        else $error("nonzero handle on a failed item");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == slfha_pkg::ST_FULL)
        |-> (o_frame_level == slfha_pkg::LEVEL_W'(slfha_pkg::FRAMES - 1)))
        else $error("stack full reported below the last frame");

    a_base_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == slfha_pkg::ST_BASE_POP) |-> (o_frame_level == '0))
        else $error("base pop reported above the base frame");

endmodule

bind scoped_lowest_free_handle_allocator_core slfha_checker u_slfha_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_granted_handle (o_granted_handle),
    .o_status         (o_status),
    .o_frame_level    (o_frame_level)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scoped lowest-free handle allocator core.
// Items are sent in bursts with random gaps. Every accepted item is run
// through a bit-level model of the frame stack, and each result strobe is
// compared field by field against the oldest predicted reply. A short
// directed pass covers each action, spare codes, a base pop. A long random
// pass follows, in segments that fill frames, churn slots, climb or unwind
// the stack, or send raw noise including the unused action codes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [slfha_pkg::ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [slfha_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [slfha_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int                             MAX_SHOWN   = 10;

    typedef struct {
        logic [slfha_pkg::HANDLE_W-1:0] handle;
        slfha_pkg::t_status             status;
        logic [slfha_pkg::LEVEL_W-1:0]  level;
    } t_alloc_reply;

    typedef enum int {
        MIX_FILL,
        MIX_CHURN,
        MIX_RISE,
        MIX_FALL,
        MIX_NOISE
    } t_mix;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           start       = 1'b0;
    logic [slfha_pkg::ACTION_W-1:0] i_action    = '0;
    logic [slfha_pkg::HANDLE_W-1:0] i_handle_id = '0;
    logic                           busy;
    logic                           o_valid;
    logic [slfha_pkg::HANDLE_W-1:0] o_granted_handle;
    logic [slfha_pkg::STATUS_W-1:0] o_status;
    logic [slfha_pkg::LEVEL_W-1:0]  o_frame_level;

    logic [slfha_pkg::SLOTS-1:0]    frame_bits [slfha_pkg::FRAMES];
    logic [slfha_pkg::FRAME_W-1:0]  top_idx;
    t_alloc_reply                   alloc_reply_q [$];

    int fail_count   = 0;
    int reply_count  = 0;
    int burst_left   = 0;
    int act_count    [8];
    int status_count [4];

    scoped_lowest_free_handle_allocator_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_handle_id      (i_handle_id),
        .o_valid          (o_valid),
        .o_granted_handle (o_granted_handle),
        .o_status         (o_status),
        .o_frame_level    (o_frame_level)
    );

    always #10 i_clk = ~i_clk;

    function automatic void note_failure(input string msg);
        if (fail_count < MAX_SHOWN) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    function automatic t_alloc_reply alloc_predict(
        input logic [slfha_pkg::ACTION_W-1:0] act,
        input logic [slfha_pkg::HANDLE_W-1:0] hid
    );
        t_alloc_reply r;
        int           slot;
        r.handle = '0;
        r.status = slfha_pkg::ST_OK;
        case (act)
            slfha_pkg::ACT_ACQUIRE: begin
                slot = -1;
                for (int k = 0; k < slfha_pkg::SLOTS; k++) begin
                    if (!frame_bits[top_idx][k]) begin
                        slot = k;
                        break;
                    end
                end
                if (slot < 0) begin
                    r.status = slfha_pkg::ST_NO_FREE;
                end else begin
                    frame_bits[top_idx][slot] = 1'b1;
                    r.handle = slfha_pkg::HANDLE_W'(slot);
                end
            end
            slfha_pkg::ACT_RELEASE: begin
                if (int'(hid) < slfha_pkg::SLOTS) frame_bits[top_idx][hid] = 1'b0;
            end
            slfha_pkg::ACT_PUSH: begin
                if (int'(top_idx) + 1 >= slfha_pkg::FRAMES) begin
                    r.status = slfha_pkg::ST_FULL;
                end else begin
                    top_idx = top_idx + 1'b1;
                    frame_bits[top_idx] = '0;
                end
            end
            slfha_pkg::ACT_POP: begin
                if (top_idx == '0) begin
                    r.status = slfha_pkg::ST_BASE_POP;
                end else begin
                    frame_bits[top_idx] = '0;
                    top_idx = top_idx - 1'b1;
                end
            end
            slfha_pkg::ACT_CLEAR: frame_bits[top_idx] = '0;
            default: ;
        endcase
        r.level = slfha_pkg::LEVEL_W'(top_idx);
        return r;
    endfunction

    // Predict on acceptance, then check any result strobe against the oldest reply.
    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (i_rst_n && start && !busy) begin
            want = alloc_predict(i_action, i_handle_id);
            alloc_reply_q.insert(alloc_reply_q.size(), want);
            act_count[i_action]++;
            status_count[want.status]++;
        end
        if (i_rst_n && o_valid === 1'b1) begin
            if (alloc_reply_q.size() == 0) begin
                note_failure($sformatf(
                    "result with nothing pending: handle %0d status %0d level %0d",
                    o_granted_handle, o_status, o_frame_level));
            end else begin
                want = alloc_reply_q.pop_front();
                reply_count++;
                if (o_granted_handle !== want.handle || o_status !== want.status ||
                    o_frame_level !== want.level) begin
                    note_failure($sformatf(
                        {"expected handle %0d status %0d level %0d, ",
                         "got handle %0d status %0d level %0d"},
                        want.handle, want.status, want.level,
                        o_granted_handle, o_status, o_frame_level));
                end
            end
        end
    end

    task automatic send_item(input logic [slfha_pkg::ACTION_W-1:0] act,
                             input logic [slfha_pkg::HANDLE_W-1:0] hid);
        if (burst_left == 0) begin
            start       <= 1'b0;
            i_action    <= slfha_pkg::ACTION_W'($urandom);
            i_handle_id <= slfha_pkg::HANDLE_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 25);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_handle_id <= hid;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        burst_left--;
    endtask

    // Taken slot of the top frame at or after hint, wrapping; hint if none.
    function automatic logic [slfha_pkg::HANDLE_W-1:0] taken_slot_near(
        input logic [slfha_pkg::HANDLE_W-1:0] hint
    );
        int k;
        for (int n = 0; n < slfha_pkg::SLOTS; n++) begin
            k = (int'(hint) + n) % slfha_pkg::SLOTS;
            if (frame_bits[top_idx][k]) return slfha_pkg::HANDLE_W'(k);
        end
        return hint;
    endfunction

    task automatic pick_item(input t_mix mode,
                             output logic [slfha_pkg::ACTION_W-1:0] act,
                             output logic [slfha_pkg::HANDLE_W-1:0] hid);
        int w;
        w   = $urandom_range(99);
        hid = slfha_pkg::HANDLE_W'($urandom);
        case (mode)
            MIX_FILL:  act = (w < 94) ? slfha_pkg::ACT_ACQUIRE : slfha_pkg::ACT_RELEASE;
            MIX_CHURN: act = (w < 45) ? slfha_pkg::ACT_ACQUIRE :
                             (w < 85) ? slfha_pkg::ACT_RELEASE :
                             (w < 92) ? slfha_pkg::ACT_PUSH    :
                             (w < 97) ? slfha_pkg::ACT_POP     : slfha_pkg::ACT_CLEAR;
            MIX_RISE:  act = (w < 60) ? slfha_pkg::ACT_PUSH    :
                             (w < 80) ? slfha_pkg::ACT_POP     :
                             (w < 95) ? slfha_pkg::ACT_ACQUIRE : slfha_pkg::ACT_CLEAR;
            MIX_FALL:  act = (w < 60) ? slfha_pkg::ACT_POP     :
                             (w < 75) ? slfha_pkg::ACT_PUSH    :
                             (w < 95) ? slfha_pkg::ACT_ACQUIRE : slfha_pkg::ACT_RELEASE;
            default:   act = slfha_pkg::ACTION_W'($urandom);
        endcase
        if (act == slfha_pkg::ACT_RELEASE && $urandom_range(3) != 0) begin
            hid = taken_slot_near(hid);
        end
    endtask

    task automatic test_directed();
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd63);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_RELEASE, 6'd1);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_RELEASE, 6'd1);
        send_item(slfha_pkg::ACT_RELEASE, 6'd1);
        send_item(slfha_pkg::ACT_RELEASE, 6'd63);
        send_item(slfha_pkg::ACT_RELEASE, 6'd0);
        send_item(slfha_pkg::ACT_PUSH,    6'd0);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_CLEAR,   6'd63);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_POP,     6'd0);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd0);
        send_item(slfha_pkg::ACT_POP,     6'd0);
        send_item(ACT_SPARE_5,            6'd63);
        send_item(ACT_SPARE_6,            6'd0);
        send_item(ACT_SPARE_7,            6'd42);
        send_item(slfha_pkg::ACT_CLEAR,   6'd0);
        send_item(slfha_pkg::ACT_ACQUIRE, 6'd21);
    endtask

    task automatic test_random_mix(input int n_items);
        int                             sent;
        int                             seg_len;
        t_mix                           mode;
        logic [slfha_pkg::ACTION_W-1:0] act;
        logic [slfha_pkg::HANDLE_W-1:0] hid;
        sent = 0;
        while (sent < n_items) begin
            mode    = t_mix'($urandom_range(4));
            seg_len = (mode == MIX_FILL) ? $urandom_range(70, 130) : $urandom_range(20, 120);
            if (seg_len > n_items - sent) seg_len = n_items - sent;
            repeat (seg_len) begin
                pick_item(mode, act, hid);
                send_item(act, hid);
                sent++;
            end
        end
    endtask

    initial begin
        foreach (frame_bits[f]) frame_bits[f] = '0;
        top_idx = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(1950);

        start <= 1'b0;
        @(posedge i_clk);
        while (alloc_reply_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (alloc_reply_q.size() != 0) begin
            note_failure($sformatf("%0d replies never arrived", alloc_reply_q.size()));
        end

        $display("Items: acquire %0d, release %0d, push %0d, pop %0d, clear %0d, unused %0d",
                 act_count[0], act_count[1], act_count[2], act_count[3], act_count[4],
                 act_count[5] + act_count[6] + act_count[7]);
        $display("Replies checked %0d (no free %0d, stack full %0d, base pop %0d), failures %0d",
                 reply_count, status_count[1], status_count[2], status_count[3], fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout waiting for the allocator");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/slfha_pkg.sv
sv/slfha_ffs.sv
sv/slfha_stack.sv
sv/scoped_lowest_free_handle_allocator_core.sv
sv/slfha_checker.sv
verif/tb.sv
